// ===== src/pl_pkg.sv =====
// shared types, codes and widths for the positional list engine
package pl_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 8;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;
  localparam int CNT_W        = POS_W + 1;
  localparam int DEF_CAPACITY = 16;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 40;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SORT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_SORT = 2'd3;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic [1:0]              op;
    logic [CNT_W-1:0]        idx;
    logic [CNT_W-1:0]        count;
    logic                    phase;
    logic signed [DATA_W-1:0] value;
  } pl_ctrl_t;

endpackage

// ===== src/pl_cell.sv =====
// one list slot: shifts with its neighbours and does one compare-exchange step
module pl_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  pl_pkg::pl_ctrl_t              ctrl,
  input  logic signed [pl_pkg::DATA_W-1:0] left_data,
  input  logic signed [pl_pkg::DATA_W-1:0] right_data,
  output logic signed [pl_pkg::DATA_W-1:0] data
);

  localparam logic [pl_pkg::CNT_W-1:0] MY_IDX  = pl_pkg::CNT_W'(IDX);
  localparam logic [pl_pkg::CNT_W-1:0] NXT_IDX = pl_pkg::CNT_W'(IDX + 1);

  logic signed [pl_pkg::DATA_W-1:0] data_r;
  logic signed [pl_pkg::DATA_W-1:0] data_nxt;
  logic                             lo_side;
  logic                             hi_side;

  // lower member of a pair keeps the minimum, upper member the maximum
  assign lo_side = (MY_IDX[0] == ctrl.phase) && (NXT_IDX < ctrl.count);
  assign hi_side = (MY_IDX[0] != ctrl.phase) && (MY_IDX != '0) && (MY_IDX < ctrl.count);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      pl_pkg::OP_INS: begin
        if (MY_IDX == ctrl.idx) begin
          data_nxt = ctrl.value;
        end else if (MY_IDX > ctrl.idx) begin
          data_nxt = left_data;
        end
      end
      pl_pkg::OP_DEL: begin
        if (MY_IDX >= ctrl.idx) begin
          data_nxt = right_data;
        end
      end
      pl_pkg::OP_SORT: begin
        if (lo_side && (data_r > right_data)) begin
          data_nxt = right_data;
        end else if (hi_side && (left_data > data_r)) begin
          data_nxt = left_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== src/positional_list_engine.sv =====
// positional list engine: command decode, sort sequencer and a row of list cells
// append, insert, delete, read and the spare codes: result registered as the item is taken
// sort: one odd-even transposition phase per entry across the cell row, then the result is registered,
//   or registered as the item is taken when the list holds fewer than two entries
// one item in flight; a new item is taken while the result register is free or being drained
// reset clears the entry count and handshake state; the cell contents are not cleared
module positional_list_engine #(
  parameter int CAPACITY = pl_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] cmd, [10:3] position, [42:11] value, [47:43] zero
  input  logic [pl_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [33:2] item_value, [38:34] count, [39] is_empty
  output logic [pl_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int          CNT_W    = pl_pkg::CNT_W;
  localparam int          DATA_W   = pl_pkg::DATA_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [CNT_W-1:0]               phase_r, phase_nxt;
  logic                           out_valid_r;
  logic [pl_pkg::STATUS_W-1:0]    out_status_r;
  logic signed [DATA_W-1:0]       out_item_r;
  logic [pl_pkg::COUNT_W-1:0]     out_count_r;
  logic                           out_empty_r;

  logic [pl_pkg::CMD_W-1:0]       in_cmd;
  logic [pl_pkg::POS_W-1:0]       in_pos;
  logic signed [DATA_W-1:0]       in_value;
  logic [CNT_W-1:0]               pos_ext;
  logic [CNT_W-1:0]               pos_idx;
  logic                           in_acc;
  logic                           out_free;
  logic                           load_out;
  logic [pl_pkg::STATUS_W-1:0]    res_status;
  logic signed [DATA_W-1:0]       res_item;
  logic signed [DATA_W-1:0]       sel_data;
  logic                           full;
  pl_pkg::pl_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  assign in_cmd   = in_tdata[2:0];
  assign in_pos   = in_tdata[10:3];
  assign in_value = in_tdata[42:11];
  assign pos_ext  = {1'b0, in_pos};
  assign pos_idx  = (in_pos == '0) ? '0 : pos_ext - CNT_W'(1);
  assign full     = (cnt_r >= CAP_CNT);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // entry picked out for read and delete
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) == pos_idx) begin
        sel_data = cell_data[i];
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    load_out   = 1'b0;
    res_status = pl_pkg::ST_OK;
    res_item   = '0;
    ctrl.op    = pl_pkg::OP_HOLD;
    ctrl.idx   = pos_idx;
    ctrl.count = cnt_r;
    ctrl.phase = phase_r[0];
    ctrl.value = in_value;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          case (in_cmd)
            pl_pkg::CMD_APPEND: begin
              if (full) begin
                res_status = pl_pkg::ST_FULL;
              end else begin
                ctrl.op  = pl_pkg::OP_INS;
                ctrl.idx = cnt_r;
                cnt_nxt  = cnt_r + CNT_W'(1);
              end
            end
            pl_pkg::CMD_INSERT: begin
              if (pos_ext > cnt_r + CNT_W'(1)) begin
                res_status = pl_pkg::ST_BADPOS;
              end else if (full) begin
                res_status = pl_pkg::ST_FULL;
              end else begin
                ctrl.op = pl_pkg::OP_INS;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            pl_pkg::CMD_DELETE: begin
              if ((in_pos == '0) || (pos_ext > cnt_r)) begin
                res_status = pl_pkg::ST_BADPOS;
              end else begin
                ctrl.op  = pl_pkg::OP_DEL;
                res_item = sel_data;
                cnt_nxt  = cnt_r - CNT_W'(1);
              end
            end
            pl_pkg::CMD_SORT: begin
              if (cnt_r > CNT_W'(1)) begin
                load_out  = 1'b0;
                state_nxt = S_SORT;
                phase_nxt = '0;
              end
            end
            pl_pkg::CMD_READ: begin
              if ((in_pos == '0) || (pos_ext > cnt_r)) begin
                res_status = pl_pkg::ST_BADPOS;
              end else begin
                res_item = sel_data;
              end
            end
            default: begin
              res_status = pl_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SORT: begin
        ctrl.op   = pl_pkg::OP_SORT;
        phase_nxt = phase_r + CNT_W'(1);
        if (phase_r == cnt_r - CNT_W'(1)) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    pl_cell #(
      .IDX(g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_data (left_in),
      .right_data(right_in),
      .data      (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_item_r   <= res_item;
      out_count_r  <= cnt_nxt[pl_pkg::COUNT_W-1:0];
      out_empty_r  <= (cnt_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_empty_r, out_count_r, out_item_r, out_status_r};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(cnt_r))
    else $error("entry count changed without an accepted item");

  a_sort_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT) |-> (cnt_r > CNT_W'(1)) && (phase_r < cnt_r))
    else $error("sort phase out of range");

  a_sort_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT) |-> !load_out && !in_tready)
    else $error("result or item taken during sort");

  a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("sort result not delivered");
`endif

endmodule

// ===== verif/tb_positional_list_engine.sv =====
// self-checking testbench for the positional list engine: directed and random command streams
module tb_positional_list_engine;

  localparam int CMD_W       = pl_pkg::CMD_W;
  localparam int POS_W       = pl_pkg::POS_W;
  localparam int DATA_W      = pl_pkg::DATA_W;
  localparam int STATUS_W    = pl_pkg::STATUS_W;
  localparam int COUNT_W     = pl_pkg::COUNT_W;
  localparam int IN_TDATA_W  = pl_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = pl_pkg::OUT_TDATA_W;

  localparam int LIST_DEPTH = pl_pkg::DEF_CAPACITY;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1330;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int MAX_REPORTS = 10;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] item_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } list_reply_t;

  // shadow copy of the list plus the replies it still owes
  class list_shadow;
    logic signed [DATA_W-1:0] slots [LIST_DEPTH];
    int unsigned              fill;
    list_reply_t              replies_due [$];
    int unsigned              failures;

    function new();
      fill = 0;
      failures = 0;
    endfunction

    function void take_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_reply_t reply;
      int unsigned idx;
      logic signed [DATA_W-1:0] tmp;
      reply.status = pl_pkg::ST_OK;
      reply.item_value = '0;
      case (cmd)
        pl_pkg::CMD_APPEND, pl_pkg::CMD_INSERT: begin
          if (cmd == pl_pkg::CMD_INSERT && pos > fill + 1) begin
            reply.status = pl_pkg::ST_BADPOS;
          end else if (fill >= LIST_DEPTH) begin
            reply.status = pl_pkg::ST_FULL;
          end else begin
            // positions 0 and 1 both mean the front
            idx = (cmd == pl_pkg::CMD_APPEND) ? fill : ((pos == 0) ? 0 : pos - 1);
            for (int k = fill; k > idx; k--) slots[k] = slots[k-1];
            slots[idx] = val;
            fill++;
          end
        end
        pl_pkg::CMD_DELETE: begin
          if (pos == 0 || pos > fill) begin
            reply.status = pl_pkg::ST_BADPOS;
          end else begin
            reply.item_value = slots[pos-1];
            for (int k = pos - 1; k + 1 < fill; k++) slots[k] = slots[k+1];
            fill--;
          end
        end
        pl_pkg::CMD_SORT: begin
          for (int i = 0; i + 1 < fill; i++) begin
            for (int j = 0; j + 1 < fill - i; j++) begin
              if (slots[j] > slots[j+1]) begin
                tmp = slots[j];
                slots[j] = slots[j+1];
                slots[j+1] = tmp;
              end
            end
          end
        end
        pl_pkg::CMD_READ: begin
          if (pos == 0 || pos > fill) reply.status = pl_pkg::ST_BADPOS;
          else reply.item_value = slots[pos-1];
        end
        default: ;
      endcase
      reply.count = fill[COUNT_W-1:0];
      reply.is_empty = (fill == 0);
      replies_due.push_back(reply);
    endfunction

    function void match_reply(logic [OUT_TDATA_W-1:0] tdata);
      list_reply_t got;
      list_reply_t want;
      got.status = tdata[1:0];
      got.item_value = tdata[33:2];
      got.count = tdata[38:34];
      got.is_empty = tdata[39];
      if (replies_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected item: status %0d value %0d count %0d empty %0b",
                   got.status, got.item_value, got.count, got.is_empty);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status || got.item_value !== want.item_value ||
          got.count !== want.count || got.is_empty !== want.is_empty) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"mismatch: expected status %0d value %0d count %0d empty %0b,",
                    " got status %0d value %0d count %0d empty %0b"},
                   want.status, want.item_value, want.count, want.is_empty,
                   got.status, got.item_value, got.count, got.is_empty);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  list_shadow shadow = new();
  int unsigned items_taken = 0;
  int unsigned stall_cycles = 0;
  bit held_once = 0;
  wire quiet = (items_taken >= 500) && (items_taken < 800);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  positional_list_engine #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // input monitor feeds the shadow list, output monitor checks against it
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      shadow.take_command(in_tdata[2:0], in_tdata[10:3], in_tdata[42:11]);
      items_taken++;
    end
    if (rst_n && out_tvalid && out_tready) shadow.match_reply(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random back-pressure, one long hold-off to fill the block
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && items_taken >= 250) begin
        held_once = 1;
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, val, pos, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] val;
    int unsigned r;
    bit filling;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corners
    send_command(pl_pkg::CMD_READ, 8'd1, 32'sd5);
    send_command(pl_pkg::CMD_DELETE, 8'd0, 32'sd0);
    send_command(pl_pkg::CMD_SORT, 8'd0, 32'sd0);
    send_command(CMD_SPARE_FIRST, 8'd3, 32'sd9);
    send_command(pl_pkg::CMD_INSERT, 8'd2, 32'sd1);
    // front insert through position 0 and 1, sort of a single entry
    send_command(pl_pkg::CMD_INSERT, 8'd0, VAL_MAX);
    send_command(pl_pkg::CMD_SORT, 8'd0, 32'sd0);
    send_command(pl_pkg::CMD_INSERT, 8'd1, VAL_MIN);
    send_command(pl_pkg::CMD_APPEND, 8'd0, -32'sd1);
    send_command(pl_pkg::CMD_INSERT, 8'd4, 32'sd0);
    send_command(pl_pkg::CMD_INSERT, 8'd6, 32'sd7);
    send_command(pl_pkg::CMD_READ, 8'd0, 32'sd0);
    send_command(pl_pkg::CMD_READ, 8'd4, 32'sd0);
    send_command(pl_pkg::CMD_READ, 8'd5, 32'sd0);
    send_command(pl_pkg::CMD_SORT, 8'd0, 32'sd0);
    send_command(pl_pkg::CMD_READ, 8'd1, 32'sd0);
    send_command(pl_pkg::CMD_DELETE, 8'd4, 32'sd0);
    send_command(pl_pkg::CMD_DELETE, 8'd1, 32'sd0);
    send_command(CMD_SPARE_MID, 8'd255, VAL_MIN);
    send_command(CMD_SPARE_LAST, 8'd255, VAL_MAX);
    send_command(pl_pkg::CMD_READ, 8'd255, 32'sd0);
    send_command(pl_pkg::CMD_DELETE, 8'd5, 32'sd0);

    // random part: alternate growing and shrinking so full and empty both recur
    filling = 1;
    repeat (RANDOM_ITEMS) begin
      if (shadow.fill == LIST_DEPTH && $urandom_range(0, 3) == 0) filling = 0;
      if (shadow.fill == 0 && $urandom_range(0, 3) == 0) filling = 1;
      r = $urandom_range(0, 99);
      if (r < 6) cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      else if (r < 14) cmd = pl_pkg::CMD_SORT;
      else if (r < 30) cmd = pl_pkg::CMD_READ;
      else if (r < (filling ? 82 : 44))
        cmd = $urandom_range(0, 1) ? pl_pkg::CMD_APPEND : pl_pkg::CMD_INSERT;
      else cmd = pl_pkg::CMD_DELETE;
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 255));
      else pos = POS_W'($urandom_range(0, shadow.fill + 1));
      r = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 3))
          0: val = VAL_MIN;
          1: val = VAL_MAX;
          2: val = '0;
          default: val = -32'sd1;
        endcase
      end else if (r < 4) begin
        // narrow range gives duplicates for the sort
        val = $signed(DATA_W'($urandom_range(0, 16)) - DATA_W'(8));
      end else begin
        val = $urandom();
      end
      send_command(cmd, pos, val);
    end
    in_tvalid <= 1'b0;

    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.failures == 0 && shadow.replies_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
